@@ hdl/avr_pkg.sv @@
`default_nettype none
package avr_pkg;

  // Field widths.
  localparam int PT_W = 32;
  localparam int AX_W = 16;
  localparam int AN_W = 16;
  localparam int LL_W = 16;

  // Sine and cosine pipeline.
  localparam int CS_W          = 30;
  localparam int CZ_W          = 34;
  localparam int CORDIC_ITERS  = 28;
  localparam int CORDIC_PER    = 2;
  localparam int CORDIC_STAGES = CORDIC_ITERS / CORDIC_PER;
  localparam int CORDIC_LAT    = CORDIC_STAGES + 2;

  localparam logic signed [CZ_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CZ_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CZ_W-1:0] ONE_Q28_CZ  = 34'sd268435456;

  // Normalisation, square root and division.
  localparam int MAG_W      = 38;
  localparam int LD_W       = 6;
  localparam int NRM_W      = 30;
  localparam int SUM_W      = 62;
  localparam int SQ_W       = 63;
  localparam int SQRT_STEPS = 32;
  localparam int ROOT_W     = 31;
  localparam int DVD_W      = 64;
  localparam int QUO_W      = 33;
  localparam int DIV_STEPS  = 33;

  // Total register levels from the input to the output register.
  localparam int LAT = CORDIC_LAT + 9 + SQRT_STEPS + 2 + DIV_STEPS + 1;

  typedef struct packed {
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic signed [PT_W-1:0] point_z;
    logic signed [AX_W-1:0] axis_x;
    logic signed [AX_W-1:0] axis_y;
    logic signed [AX_W-1:0] axis_z;
    logic signed [AN_W-1:0] angle;
  } avr_in_t;

  typedef struct packed {
    logic signed [PT_W-1:0] out_x;
    logic signed [PT_W-1:0] out_y;
    logic signed [PT_W-1:0] out_z;
    logic                   zero_norm;
  } avr_out_t;

  // Arctangent steps in Q30, rounded.
  function automatic logic signed [CZ_W-1:0] atan_q30(input int idx);
    logic signed [CZ_W-1:0] v;
    case (idx)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      24: v = 34'sd64;
      25: v = 34'sd32;
      26: v = 34'sd16;
      27: v = 34'sd8;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ hdl/avr_cordic.sv @@
`default_nettype none
module avr_cordic import avr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic signed [AN_W-1:0] angle,
  output logic signed [CS_W-1:0]      cos_q,
  output logic signed [CS_W-1:0]      sin_q
);

  logic signed [CZ_W-1:0] x_r [CORDIC_STAGES+1];
  logic signed [CZ_W-1:0] y_r [CORDIC_STAGES+1];
  logic signed [CZ_W-1:0] z_r [CORDIC_STAGES+1];
  logic                   flip_r [CORDIC_STAGES+1];
  logic signed [CS_W-1:0] cos_r, sin_r;

  logic signed [CZ_W-1:0] z_ang, z_fold;
  logic                   flip;

  // Fold the angle into the range of the rotation.
  always_comb begin
    z_ang  = {angle[AN_W-1], angle, 17'b0};
    z_fold = z_ang;
    flip   = 1'b0;
    if (z_ang > HALF_PI_Q30) begin
      z_fold = z_ang - PI_Q30;
      flip   = 1'b1;
    end else if (z_ang < -HALF_PI_Q30) begin
      z_fold = z_ang + PI_Q30;
      flip   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= CORDIC_GAIN;
      y_r[0]    <= '0;
      z_r[0]    <= z_fold;
      flip_r[0] <= flip;
    end
  end

  // Each stage performs a fixed pair of rotation steps.
  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_it
    logic signed [CZ_W-1:0] xc, yc, zc;

    always_comb begin
      logic signed [CZ_W-1:0] dx, dy;
      xc = x_r[j];
      yc = y_r[j];
      zc = z_r[j];
      for (int k = 0; k < CORDIC_PER; k++) begin
        dx = yc >>> (j * CORDIC_PER + k);
        dy = xc >>> (j * CORDIC_PER + k);
        if (!zc[CZ_W-1]) begin
          xc = xc - dx;
          yc = yc + dy;
          zc = zc - atan_q30(j * CORDIC_PER + k);
        end else begin
          xc = xc + dx;
          yc = yc - dy;
          zc = zc + atan_q30(j * CORDIC_PER + k);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[j+1]    <= xc;
        y_r[j+1]    <= yc;
        z_r[j+1]    <= zc;
        flip_r[j+1] <= flip_r[j];
      end
    end
  end

  // Round to Q28, clamp to one and undo the fold.
  logic signed [CZ_W-1:0] xr, yr;

  always_comb begin
    xr = (x_r[CORDIC_STAGES] + 34'sd2) >>> 2;
    yr = (y_r[CORDIC_STAGES] + 34'sd2) >>> 2;
    if (xr > ONE_Q28_CZ) xr = ONE_Q28_CZ;
    if (xr < -ONE_Q28_CZ) xr = -ONE_Q28_CZ;
    if (yr > ONE_Q28_CZ) yr = ONE_Q28_CZ;
    if (yr < -ONE_Q28_CZ) yr = -ONE_Q28_CZ;
    if (flip_r[CORDIC_STAGES]) begin
      xr = -xr;
      yr = -yr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= xr[CS_W-1:0];
      sin_r <= yr[CS_W-1:0];
    end
  end

  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule
`default_nettype wire

@@ hdl/avr_div.sv @@
`default_nettype none
module avr_div import avr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [DVD_W-1:0]  dvd,
  input  wire logic [ROOT_W-1:0] dsr,
  output logic      [QUO_W-1:0]  quo
);

  logic [DVD_W-1:0]  rem_r [DIV_STEPS];
  logic [ROOT_W-1:0] dsr_r [DIV_STEPS];
  logic [QUO_W-1:0]  quo_r [DIV_STEPS];

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_st
    logic [DVD_W-1:0]  r_in;
    logic [ROOT_W-1:0] d_in;
    logic [QUO_W-1:0]  q_in;
    logic [DVD_W-1:0]  trial, r_nxt;
    logic              q_bit;

    if (k == 0) begin : g_first
      assign r_in = dvd;
      assign d_in = dsr;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_r[k-1];
      assign d_in = dsr_r[k-1];
      assign q_in = quo_r[k-1];
    end

    always_comb begin
      trial = DVD_W'(d_in) << (DIV_STEPS - 1 - k);
      q_bit = (r_in >= trial);
      r_nxt = q_bit ? (r_in - trial) : r_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= r_nxt;
        dsr_r[k] <= d_in;
        quo_r[k] <= {q_in[QUO_W-2:0], q_bit};
      end
    end
  end

  assign quo = quo_r[DIV_STEPS-1];

endmodule
`default_nettype wire

@@ hdl/axis_angle_vector_rotate.sv @@
// Axis-angle vector rotation with rescaling to a fixed length.
//
// The input channel (in_valid, in_ready, in_data) carries one request per
// point: the point, a unit axis and an angle. The result channel (out_valid,
// out_ready, out_data) returns one request per input, in order: the rotated
// vector scaled to the target length, or zero with zero_norm set. The target
// length is written through cfg_we and cfg_wdata, and should change only
// while the block is empty.
//
// The block is one pipeline of 93 register stages, and it takes one request
// every cycle unless out_ready is low with a result waiting.
// The depth is set by the 16 stage sine and cosine unit, the 32 stage
// square root and the 33 stage dividers, one quotient bit per stage.
//
// Reset empties the pipeline and loads the target length with 50. When the
// receiver holds out_ready low with a result waiting, the whole pipeline
// holds and in_ready falls; nothing is lost or repeated.
`default_nettype none
module axis_angle_vector_rotate import avr_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire avr_in_t         in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output avr_out_t             out_data,
  input  wire logic            cfg_we,
  input  wire logic [LL_W-1:0] cfg_wdata
);

  typedef struct packed {
    logic [2:0][PT_W-1:0] p;
    logic [2:0][AX_W-1:0] a;
    logic [35:0]          dot;
    logic [2:0][34:0]     cr;
  } side_t;

  localparam int DLY = CORDIC_LAT - 2;
  localparam logic [LD_W-1:0] NRM_LEAD = LD_W'(NRM_W - 1);

  logic            en;
  logic [LAT-1:0]  vld_r;
  logic [LL_W-1:0] limb_r;

  // Pipeline advance and valid bits.
  assign en       = ~vld_r[LAT-1] | out_ready;
  assign in_ready = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limb_r <= LL_W'(50);
    end else if (cfg_we) begin
      limb_r <= cfg_wdata;
    end
  end

  // Sine and cosine of the angle.
  logic signed [CS_W-1:0] cos_q, sin_q;

  avr_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .angle (in_data.angle),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  // Level 1: all point by axis products.
  logic signed [PT_W-1:0] p_in [3];
  logic signed [AX_W-1:0] a_in [3];
  logic signed [PT_W-1:0] l1_p_r [3];
  logic signed [AX_W-1:0] l1_a_r [3];
  logic signed [47:0]     l1_pa_r [3][3];

  assign p_in[0] = in_data.point_x;
  assign p_in[1] = in_data.point_y;
  assign p_in[2] = in_data.point_z;
  assign a_in[0] = in_data.axis_x;
  assign a_in[1] = in_data.axis_y;
  assign a_in[2] = in_data.axis_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        l1_p_r[i] <= p_in[i];
        l1_a_r[i] <= a_in[i];
        for (int j = 0; j < 3; j++) begin
          l1_pa_r[i][j] <= p_in[i] * a_in[j];
        end
      end
    end
  end

  // Level 2: dot and cross products, rounded down to Q16.
  side_t              l2_nxt, l2_r;
  logic signed [49:0] dsum;
  logic signed [48:0] cdif [3];

  always_comb begin
    dsum = 50'(l1_pa_r[0][0]) + 50'(l1_pa_r[1][1]) + 50'(l1_pa_r[2][2]);
    cdif[0] = 49'(l1_pa_r[1][2]) - 49'(l1_pa_r[2][1]);
    cdif[1] = 49'(l1_pa_r[2][0]) - 49'(l1_pa_r[0][2]);
    cdif[2] = 49'(l1_pa_r[0][1]) - 49'(l1_pa_r[1][0]);
    l2_nxt.dot = 36'((dsum + 50'sd8192) >>> 14);
    for (int i = 0; i < 3; i++) begin
      l2_nxt.p[i]  = l1_p_r[i];
      l2_nxt.a[i]  = l1_a_r[i];
      l2_nxt.cr[i] = 35'((cdif[i] + 49'sd8192) >>> 14);
    end
  end

  // Delay the products to meet the sine and cosine.
  side_t dly_r [DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      l2_r     <= l2_nxt;
      dly_r[0] <= l2_r;
      for (int k = 1; k < DLY; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  // Level 17: products with the sine and cosine.
  side_t              s16;
  logic signed [30:0] omc;
  logic signed [61:0] pc_r [3];
  logic signed [64:0] cs_r [3];
  logic signed [66:0] de_r;
  logic signed [AX_W-1:0] l17_a_r [3];

  assign s16 = dly_r[DLY-1];
  assign omc = 31'sd268435456 - 31'(cos_q);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pc_r[i]    <= $signed(s16.p[i]) * cos_q;
        cs_r[i]    <= $signed(s16.cr[i]) * sin_q;
        l17_a_r[i] <= $signed(s16.a[i]);
      end
      de_r <= $signed(s16.dot) * omc;
    end
  end

  // Level 18: round the products back.
  logic signed [33:0] t1_r [3];
  logic signed [36:0] t2_r [3];
  logic signed [36:0] e_r;
  logic signed [AX_W-1:0] l18_a_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t1_r[i]    <= 34'((pc_r[i] + 62'sd134217728) >>> 28);
        t2_r[i]    <= 37'((cs_r[i] + 65'sd134217728) >>> 28);
        l18_a_r[i] <= l17_a_r[i];
      end
      e_r <= 37'((de_r + 67'sd134217728) >>> 28);
    end
  end

  // Level 19: axis term and the sum of the first two terms.
  logic signed [52:0] ae_r [3];
  logic signed [37:0] t12_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ae_r[i]  <= l18_a_r[i] * e_r;
        t12_r[i] <= 38'(t1_r[i]) + 38'(t2_r[i]);
      end
    end
  end

  // Level 20: rotated vector, split into magnitude and sign.
  logic signed [38:0] rr [3];
  logic [MAG_W-1:0]   mag_r [3];
  logic [2:0]         sg20_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rr[i] = 39'(t12_r[i]) + 39'((ae_r[i] + 53'sd8192) >>> 14);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i]  <= rr[i][38] ? MAG_W'(-rr[i]) : MAG_W'(rr[i]);
        sg20_r[i] <= rr[i][38];
      end
    end
  end

  // Level 21: largest magnitude.
  logic [MAG_W-1:0] mx_nxt, mx_r;
  logic [MAG_W-1:0] mag21_r [3];
  logic [2:0]       sg21_r;

  always_comb begin
    mx_nxt = mag_r[0];
    if (mag_r[1] > mx_nxt) mx_nxt = mag_r[1];
    if (mag_r[2] > mx_nxt) mx_nxt = mag_r[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r    <= mx_nxt;
      mag21_r <= mag_r;
      sg21_r  <= sg20_r;
    end
  end

  // Level 22: position of the leading one.
  logic [LD_W-1:0]  ld_nxt, ld_r;
  logic [MAG_W-1:0] mag22_r [3];
  logic [2:0]       sg22_r;
  logic             z22_r;

  always_comb begin
    ld_nxt = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (mx_r[b]) ld_nxt = LD_W'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ld_r    <= ld_nxt;
      mag22_r <= mag21_r;
      sg22_r  <= sg21_r;
      z22_r   <= (mx_r == '0);
    end
  end

  // Level 23: common shift that puts the largest into [2^29, 2^30).
  logic [MAG_W-1:0] shv [3];
  logic [NRM_W-1:0] m23_r [3];
  logic [2:0]       sg23_r;
  logic             z23_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ld_r >= NRM_LEAD) begin
        shv[i] = mag22_r[i] >> (ld_r - NRM_LEAD);
      end else begin
        shv[i] = mag22_r[i] << (NRM_LEAD - ld_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m23_r[i] <= shv[i][NRM_W-1:0];
      end
      sg23_r <= sg22_r;
      z23_r  <= z22_r;
    end
  end

  // Level 24: squares.
  logic [2*NRM_W-1:0] sqr_r [3];
  logic [NRM_W-1:0]   m24_r [3];
  logic [2:0]         sg24_r;
  logic               z24_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sqr_r[i] <= (2*NRM_W)'(m23_r[i]) * (2*NRM_W)'(m23_r[i]);
      end
      m24_r  <= m23_r;
      sg24_r <= sg23_r;
      z24_r  <= z23_r;
    end
  end

  // Level 25 and the square root stages, two radicand bits per stage.
  logic [SQ_W-1:0]  sv_r   [SQRT_STEPS+1];
  logic [SQ_W-1:0]  sres_r [SQRT_STEPS+1];
  logic [NRM_W-1:0] sm_r   [SQRT_STEPS+1][3];
  logic [2:0]       ssg_r  [SQRT_STEPS+1];
  logic             sz_r   [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sv_r[0]   <= SQ_W'(SUM_W'(sqr_r[0]) + SUM_W'(sqr_r[1]) + SUM_W'(sqr_r[2]));
      sres_r[0] <= '0;
      sm_r[0]   <= m24_r;
      ssg_r[0]  <= sg24_r;
      sz_r[0]   <= z24_r;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] SQ_ONE = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [SQ_W-1:0] trial, v_nxt, res_nxt;

    always_comb begin
      trial = sres_r[k] + SQ_ONE;
      if (sv_r[k] >= trial) begin
        v_nxt   = sv_r[k] - trial;
        res_nxt = (sres_r[k] >> 1) + SQ_ONE;
      end else begin
        v_nxt   = sv_r[k];
        res_nxt = sres_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sv_r[k+1]   <= v_nxt;
        sres_r[k+1] <= res_nxt;
        sm_r[k+1]   <= sm_r[k];
        ssg_r[k+1]  <= ssg_r[k];
        sz_r[k+1]   <= sz_r[k];
      end
    end
  end

  // Level 58: magnitude times the limb length.
  logic [ROOT_W-1:0] n_sq;
  logic [45:0]       prod_r [3];
  logic [ROOT_W-1:0] n58_r, n59_r;
  logic [2:0]        sg58_r, sg59_r;
  logic              z58_r, z59_r;
  logic [DVD_W-1:0]  dvd_r [3];

  assign n_sq = sres_r[SQRT_STEPS][ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= 46'(sm_r[SQRT_STEPS][i]) * 46'(limb_r);
      end
      n58_r  <= n_sq;
      sg58_r <= ssg_r[SQRT_STEPS];
      z58_r  <= sz_r[SQRT_STEPS];
    end
  end

  // Level 59: dividend in Q16 with half the divisor added for rounding.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dvd_r[i] <= DVD_W'({prod_r[i], 16'b0}) + DVD_W'(n58_r >> 1);
      end
      n59_r  <= n58_r;
      sg59_r <= sg58_r;
      z59_r  <= z58_r;
    end
  end

  // Dividers, one per component.
  logic [QUO_W-1:0] quo [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    avr_div u_div (
      .clk (clk),
      .en  (en),
      .dvd (dvd_r[i]),
      .dsr (n59_r),
      .quo (quo[i])
    );
  end

  // Signs and zero flag ride alongside the dividers.
  logic [2:0] dsg_r [DIV_STEPS];
  logic       dz_r  [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      dsg_r[0] <= sg59_r;
      dz_r[0]  <= z59_r;
      for (int k = 1; k < DIV_STEPS; k++) begin
        dsg_r[k] <= dsg_r[k-1];
        dz_r[k]  <= dz_r[k-1];
      end
    end
  end

  // Output register: restore signs, saturate, force zero.
  logic [PT_W-1:0] ov [3];
  avr_out_t        out_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dz_r[DIV_STEPS-1]) begin
        ov[i] = '0;
      end else if (dsg_r[DIV_STEPS-1][i]) begin
        if (quo[i] > QUO_W'(33'h080000000)) ov[i] = 32'h80000000;
        else ov[i] = -quo[i][PT_W-1:0];
      end else begin
        if (quo[i] > QUO_W'(33'h07FFFFFFF)) ov[i] = 32'h7FFFFFFF;
        else ov[i] = quo[i][PT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.out_x     <= ov[0];
      out_r.out_y     <= ov[1];
      out_r.out_z     <= ov[2];
      out_r.zero_norm <= dz_r[DIV_STEPS-1];
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire
